FILE: design/phs_pkg.sv
// Shared types, constants and table functions of the phasor add/subtract block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package phs_pkg;

    // Defaults of the top-level parameters.
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int DEF_DATA_WIDTH    = 16;

    // Fraction bits carried by amplitudes inside the CORDIC.
    localparam int GUARD = 8;
    // Binary angles inside the block: 2^32 is one full turn.
    localparam int ANG_W = 32;
    // Rotation residual angle, one sign bit above the binary angle.
    localparam int ZW    = ANG_W + 1;
    // Frequency tolerance register width.
    localparam int TOL_W = 16;
    // Width of the gain reciprocal constant.
    localparam int RW    = 28;

    // Control bits that travel beside the data through every stage.
    typedef struct packed {
        logic vld;
        logic mism;
        logic zero;
        logic sub;
    } t_ctl;

    // Arctangent of 2^-idx as a binary angle.
    function automatic logic [ANG_W-1:0] atan_at(input int idx);
        logic [ANG_W-1:0] v;
        v = '0;
        unique case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Squared CORDIC gain P in Q2.30; the user takes 2^58 / P as its reciprocal.
    function automatic logic [63:0] gain_prod(input int stages);
        logic [63:0] p;
        p = 64'd1 << 30;
        for (int i = 0; i < stages; i++) begin
            p = p + (p >> (2 * i));
        end
        return p;
    endfunction

endpackage

FILE: design/phs_norm.sv
// Operand normalization: non-negative frequency and amplitude, binary-angle phase.
// Depends on phs_pkg.
`timescale 1ns / 1ps

module phs_norm #(
    parameter int DATA_WIDTH = phs_pkg::DEF_DATA_WIDTH
) (
    input  logic signed [DATA_WIDTH-1:0]   i_amp,
    input  logic signed [DATA_WIDTH-1:0]   i_freq,
    input  logic signed [DATA_WIDTH-1:0]   i_phase,
    output logic        [DATA_WIDTH:0]     o_amp,
    output logic        [phs_pkg::ANG_W-1:0] o_ang,
    output logic        [DATA_WIDTH-1:0]   o_freq
);

    logic signed [DATA_WIDTH+1:0] c_a;
    logic signed [DATA_WIDTH:0]   c_f;
    logic        [DATA_WIDTH-1:0] c_p;

    // A negative frequency flips the whole sinusoid, then a negative amplitude adds pi.
    always_comb begin
        c_a = (DATA_WIDTH+2)'(i_amp);
        c_f = (DATA_WIDTH+1)'(i_freq);
        c_p = i_phase;
        if (c_f < 0) begin
            c_f = -c_f;
            c_p = -c_p;
            c_a = -c_a;
        end
        if (c_a < 0) begin
            c_a = -c_a;
            c_p = c_p ^ (DATA_WIDTH'(1) << (DATA_WIDTH - 1));
        end
    end

    assign o_amp  = c_a[DATA_WIDTH:0];
    assign o_freq = c_f[DATA_WIDTH-1:0];
    assign o_ang  = phs_pkg::ANG_W'(c_p) << (phs_pkg::ANG_W - DATA_WIDTH);

endmodule

FILE: design/phs_rot_stage.sv
// One registered CORDIC rotation step, driven by the sign of the residual angle.
// Depends on phs_pkg.
`timescale 1ns / 1ps

module phs_rot_stage #(
    parameter int W   = 28,
    parameter int IDX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [W-1:0]           i_x,
    input  logic signed [W-1:0]           i_y,
    input  logic signed [phs_pkg::ZW-1:0] i_z,
    output logic signed [W-1:0]           o_x,
    output logic signed [W-1:0]           o_y,
    output logic signed [phs_pkg::ZW-1:0] o_z
);

    logic signed [W-1:0]           c_dx;
    logic signed [W-1:0]           c_dy;
    logic signed [phs_pkg::ZW-1:0] c_atan;
    logic signed [W-1:0]           r_x;
    logic signed [W-1:0]           r_y;
    logic signed [phs_pkg::ZW-1:0] r_z;

    assign c_dx   = i_y >>> IDX;
    assign c_dy   = i_x >>> IDX;
    assign c_atan = signed'({1'b0, phs_pkg::atan_at(IDX)});

    // Rotate toward a zero residual angle.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[phs_pkg::ZW-1]) begin
                r_x <= i_x - c_dx;
                r_y <= i_y + c_dy;
                r_z <= i_z - c_atan;
            end else begin
                r_x <= i_x + c_dx;
                r_y <= i_y - c_dy;
                r_z <= i_z + c_atan;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

FILE: design/phs_vec_stage.sv
// One registered CORDIC vectoring step, driven by the sign of y; accumulates the angle.
// Depends on phs_pkg.
`timescale 1ns / 1ps

module phs_vec_stage #(
    parameter int W   = 28,
    parameter int IDX = 0
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [W-1:0]              i_x,
    input  logic signed [W-1:0]              i_y,
    input  logic        [phs_pkg::ANG_W-1:0] i_acc,
    output logic signed [W-1:0]              o_x,
    output logic signed [W-1:0]              o_y,
    output logic        [phs_pkg::ANG_W-1:0] o_acc
);

    logic signed [W-1:0]              c_dx;
    logic signed [W-1:0]              c_dy;
    logic        [phs_pkg::ANG_W-1:0] c_atan;
    logic signed [W-1:0]              r_x;
    logic signed [W-1:0]              r_y;
    logic        [phs_pkg::ANG_W-1:0] r_acc;

    assign c_dx   = i_y >>> IDX;
    assign c_dy   = i_x >>> IDX;
    assign c_atan = phs_pkg::atan_at(IDX);

    // Drive y toward zero; the angle wraps modulo one turn.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y[W-1]) begin
                r_x   <= i_x + c_dx;
                r_y   <= i_y - c_dy;
                r_acc <= i_acc + c_atan;
            end else begin
                r_x   <= i_x - c_dx;
                r_y   <= i_y + c_dy;
                r_acc <= i_acc - c_atan;
            end
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_acc = r_acc;

endmodule

FILE: design/phasor_add_subtract.sv
// Top level of the phasor add/subtract block: normalization, CORDIC rotation,
// add/subtract, CORDIC vectoring and gain correction. Depends on phs_pkg and all phs_ modules.
`timescale 1ns / 1ps

//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------------
//  input     | i_valid / o_ready          | amp, freq, phase of a and b, subtract
//  result    | o_valid / i_ready          | amp_out, phase_out, freq_out, freq_mismatch
//  config    | i_cfg_valid / o_cfg_ready  | i_cfg_data -> freq_tolerance
//
// One transaction enters per cycle while the output is not stalled; the result passes through
// the two unrolled CORDIC chains of one stage per iteration plus seven stages
// for normalization, pre-rotation, add, pre-vectoring, rounding, multiply and output.
// Reset clears the valid bits of all stages and the tolerance register.
// A stall at the output freezes the whole pipeline; o_ready is low only while a
// finished result waits and the result side is not ready.

module phasor_add_subtract #(
    parameter int CORDIC_STAGES = phs_pkg::DEF_CORDIC_STAGES,
    parameter int DATA_WIDTH    = phs_pkg::DEF_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_amp_a,
    input  logic signed [DATA_WIDTH-1:0] i_freq_a,
    input  logic signed [DATA_WIDTH-1:0] i_phase_a,
    input  logic signed [DATA_WIDTH-1:0] i_amp_b,
    input  logic signed [DATA_WIDTH-1:0] i_freq_b,
    input  logic signed [DATA_WIDTH-1:0] i_phase_b,
    input  logic                         i_subtract,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic        [DATA_WIDTH:0]   o_amp_out,
    output logic signed [DATA_WIDTH-1:0] o_phase_out,
    output logic        [DATA_WIDTH-1:0] o_freq_out,
    output logic                         o_freq_mismatch,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [phs_pkg::TOL_W-1:0]    i_cfg_data
);

    localparam int N      = CORDIC_STAGES;
    localparam int W      = DATA_WIDTH + phs_pkg::GUARD + 4;
    localparam int AW     = phs_pkg::ANG_W;
    localparam int ZW     = phs_pkg::ZW;
    localparam int RW     = phs_pkg::RW;
    localparam int RAW_W  = W - phs_pkg::GUARD;
    localparam int PW     = RAW_W + RW;
    localparam int SH     = AW - DATA_WIDTH;
    localparam int L      = 2 * N + 7;
    localparam int K_ADD  = N + 2;
    localparam int CW     = (DATA_WIDTH + 1 > phs_pkg::TOL_W) ? DATA_WIDTH + 1 : phs_pkg::TOL_W;
    localparam logic [RW-1:0] GAIN_R = RW'((64'd1 << 58) / phs_pkg::gain_prod(N));

    logic c_en;

    // Control bits and frequency travel beside the data.
    phs_pkg::t_ctl         r_ctl [L];
    phs_pkg::t_ctl         n_ctl [L];
    logic [DATA_WIDTH-1:0] r_fd [1:L-1];

    // Frequency tolerance register.
    logic [phs_pkg::TOL_W-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Whole pipeline advances unless a finished result is held.
    assign c_en    = !r_ctl[L-1].vld || i_ready;
    assign o_ready = c_en;

    // Stage 0: normalized operands.
    logic [DATA_WIDTH:0]   c_aa, c_ab, r_aa, r_ab;
    logic [AW-1:0]         c_za, c_zb, r_za, r_zb;
    logic [DATA_WIDTH-1:0] c_fa, c_fb, r_fa, r_fb;

    phs_norm #(.DATA_WIDTH(DATA_WIDTH)) u_norm_a (
        .i_amp(i_amp_a), .i_freq(i_freq_a), .i_phase(i_phase_a),
        .o_amp(c_aa), .o_ang(c_za), .o_freq(c_fa)
    );

    phs_norm #(.DATA_WIDTH(DATA_WIDTH)) u_norm_b (
        .i_amp(i_amp_b), .i_freq(i_freq_b), .i_phase(i_phase_b),
        .o_amp(c_ab), .o_ang(c_zb), .o_freq(c_fb)
    );

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_aa <= c_aa;
            r_ab <= c_ab;
            r_za <= c_za;
            r_zb <= c_zb;
            r_fa <= c_fa;
            r_fb <= c_fb;
        end
    end

    // Stage 1: frequency check and quadrant fold before rotation.
    logic signed [CW:0]   c_fdiff;
    logic                 c_mism;
    logic signed [W-1:0]  w_xa [0:N];
    logic signed [W-1:0]  w_ya [0:N];
    logic signed [ZW-1:0] w_za [0:N];
    logic signed [W-1:0]  w_xb [0:N];
    logic signed [W-1:0]  w_yb [0:N];
    logic signed [ZW-1:0] w_zb [0:N];
    logic signed [W-1:0]  c_xa0, c_xb0;
    logic signed [ZW-1:0] c_za0, c_zb0;

    assign c_fdiff = signed'((CW+1)'(r_fa)) - signed'((CW+1)'(r_fb));
    assign c_mism  = ((c_fdiff < 0) ? -c_fdiff : c_fdiff) > signed'((CW+1)'(r_tol));

    // An angle beyond a quarter turn is folded by pi with x negated.
    always_comb begin
        c_xa0 = signed'(W'(r_aa) << phs_pkg::GUARD);
        c_za0 = ZW'(signed'(r_za));
        if (c_za0 > (ZW'(1) <<< 30) || c_za0 < -(ZW'(1) <<< 30)) begin
            c_xa0 = -c_xa0;
            c_za0 = ZW'(signed'(r_za + (AW'(1) << (AW - 1))));
        end
        c_xb0 = signed'(W'(r_ab) << phs_pkg::GUARD);
        c_zb0 = ZW'(signed'(r_zb));
        if (c_zb0 > (ZW'(1) <<< 30) || c_zb0 < -(ZW'(1) <<< 30)) begin
            c_xb0 = -c_xb0;
            c_zb0 = ZW'(signed'(r_zb + (AW'(1) << (AW - 1))));
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            w_xa[0] <= c_xa0;
            w_ya[0] <= '0;
            w_za[0] <= c_za0;
            w_xb[0] <= c_xb0;
            w_yb[0] <= '0;
            w_zb[0] <= c_zb0;
        end
    end

    // Rotation chains, one stage per iteration.
    for (genvar gi = 0; gi < N; gi++) begin : g_rot
        phs_rot_stage #(.W(W), .IDX(gi)) u_rot_a (
            .i_clk(i_clk), .i_en(c_en),
            .i_x(w_xa[gi]), .i_y(w_ya[gi]), .i_z(w_za[gi]),
            .o_x(w_xa[gi+1]), .o_y(w_ya[gi+1]), .o_z(w_za[gi+1])
        );
        phs_rot_stage #(.W(W), .IDX(gi)) u_rot_b (
            .i_clk(i_clk), .i_en(c_en),
            .i_x(w_xb[gi]), .i_y(w_yb[gi]), .i_z(w_zb[gi]),
            .o_x(w_xb[gi+1]), .o_y(w_yb[gi+1]), .o_z(w_zb[gi+1])
        );
    end

    // Add or subtract the rectangular forms.
    logic signed [W-1:0] c_sx, c_sy, r_sx, r_sy;
    logic                c_zero;

    assign c_sx   = r_ctl[K_ADD-1].sub ? w_xa[N] - w_xb[N] : w_xa[N] + w_xb[N];
    assign c_sy   = r_ctl[K_ADD-1].sub ? w_ya[N] - w_yb[N] : w_ya[N] + w_yb[N];
    assign c_zero = (c_sx == '0) && (c_sy == '0);

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_sx <= c_sx;
            r_sy <= c_sy;
        end
    end

    // Pre-vectoring: move the vector into the right half plane.
    logic signed [W-1:0] w_vx [0:N];
    logic signed [W-1:0] w_vy [0:N];
    logic [AW-1:0]       w_acc [0:N];

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            if (r_sx[W-1]) begin
                w_vx[0]  <= -r_sx;
                w_vy[0]  <= -r_sy;
                w_acc[0] <= AW'(1) << (AW - 1);
            end else begin
                w_vx[0]  <= r_sx;
                w_vy[0]  <= r_sy;
                w_acc[0] <= '0;
            end
        end
    end

    for (genvar gv = 0; gv < N; gv++) begin : g_vec
        phs_vec_stage #(.W(W), .IDX(gv)) u_vec (
            .i_clk(i_clk), .i_en(c_en),
            .i_x(w_vx[gv]), .i_y(w_vy[gv]), .i_acc(w_acc[gv]),
            .o_x(w_vx[gv+1]), .o_y(w_vy[gv+1]), .o_acc(w_acc[gv+1])
        );
    end

    // Rounding of magnitude and angle, then gain correction and saturation.
    logic signed [W-1:0]   c_mag_rnd;
    logic [AW:0]           c_ph_sum;
    logic [RAW_W-1:0]      r_raw;
    logic [DATA_WIDTH-1:0] r_phr, r_phm, r_ph;
    logic [PW-1:0]         r_prod;
    logic [PW:0]           c_amp_sum;
    logic [PW:0]           c_amp_full;
    logic [DATA_WIDTH:0]   c_amp, r_amp;

    assign c_mag_rnd = w_vx[N] + W'(1 << (phs_pkg::GUARD - 1));
    assign c_ph_sum  = {w_acc[N], 1'b0} + ((AW+1)'(1) << SH);

    assign c_amp_sum  = (PW+1)'(r_prod) + ((PW+1)'(1) << 27);
    assign c_amp_full = c_amp_sum >> 28;

    always_comb begin
        if (c_amp_full > ((PW+1)'(1) << DATA_WIDTH)) begin
            c_amp = (DATA_WIDTH+1)'(1) << DATA_WIDTH;
        end else begin
            c_amp = c_amp_full[DATA_WIDTH:0];
        end
        if (r_ctl[L-2].mism || r_ctl[L-2].zero) begin
            c_amp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_raw  <= RAW_W'(c_mag_rnd >>> phs_pkg::GUARD);
            r_phr  <= c_ph_sum[AW:SH+1];
            r_prod <= PW'(r_raw) * PW'(GAIN_R);
            r_phm  <= r_phr;
            r_amp  <= c_amp;
            r_ph   <= (r_ctl[L-2].mism || r_ctl[L-2].zero) ? '0 : r_phm;
        end
    end

    // Control pipeline: the mismatch and zero flags join at their stages.
    always_comb begin
        n_ctl[0] = '{vld: i_valid, mism: 1'b0, zero: 1'b0, sub: i_subtract};
        for (int k = 1; k < L; k++) begin
            n_ctl[k] = r_ctl[k-1];
        end
        n_ctl[1].mism     = c_mism;
        n_ctl[K_ADD].zero = c_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (c_en) begin
            for (int k = 0; k < L; k++) begin
                r_ctl[k] <= n_ctl[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_fd[1] <= r_fa;
            for (int k = 2; k < L; k++) begin
                r_fd[k] <= r_fd[k-1];
            end
        end
    end

    assign o_valid         = r_ctl[L-1].vld;
    assign o_amp_out       = r_amp;
    assign o_phase_out     = signed'(r_ph);
    assign o_freq_out      = r_ctl[L-1].mism ? '0 : r_fd[L-1];
    assign o_freq_mismatch = r_ctl[L-1].mism;

`ifndef SYNTHESIS
    a_mism_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_freq_mismatch |-> o_amp_out == '0 && o_phase_out == '0)
        else $error("mismatch result not forced to zero");
    a_amp_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_amp_out <= ((DATA_WIDTH+1)'(1) << DATA_WIDTH))
        else $error("amplitude above saturation limit");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_ctl[0].vld)
        else $error("accepted transaction missing from first stage");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_amp) && $stable(r_ph))
        else $error("held result changed during stall");
`endif

endmodule
